/* hw/rtl/gnc_pkg.sv */
// Shared constants and types for the 3x3 grid neighbor counter.
// No dependencies; every other file imports this package.
package gnc_pkg;

    localparam int MAX_COLS = 32;
    localparam int ROW_W    = 32;
    localparam int NCOL_W   = $clog2(MAX_COLS + 1);
    localparam int COL_W    = 5;
    localparam int CNT_W    = 4;
    localparam int CFG_W    = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register indexes on the configuration port
    localparam logic REG_GRID_COLS = 1'b0;

    localparam logic [CFG_W-1:0] GRID_COLS_RESET = CFG_W'(32);

    // One row of counts to emit: the three rows of the window and its tags
    typedef struct packed {
        logic [ROW_W-1:0]  above;
        logic [ROW_W-1:0]  mid;
        logic [ROW_W-1:0]  below;
        logic [NCOL_W-1:0] ncols;
        logic              newest;
        logic              last;
    } t_job;

endpackage

/* hw/rtl/gnc_row_if.sv */
// Input channel: one grid row per transfer.
// Depends on gnc_pkg for the row width.
interface gnc_row_if
    import gnc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_bits;
    logic             last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);
endinterface

/* hw/rtl/gnc_count_if.sv */
// Output channel: one cell count per transfer.
// Depends on gnc_pkg for field widths.
interface gnc_count_if
    import gnc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] cell_count;
    logic [COL_W-1:0] column;
    logic             newest_row;
    logic             last;

    modport source (output valid, output cell_count, output column,
                    output newest_row, output last, input ready);
    modport sink   (input valid, input cell_count, input column,
                    input newest_row, input last, output ready);
endinterface

/* hw/rtl/gnc_front.sv */
// Front end: takes rows, keeps the two-row history and turns each row
// into zero, one or two count jobs. Depends on gnc_pkg and gnc_row_if.
module gnc_front
    import gnc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [NCOL_W-1:0] i_ncols,
    gnc_row_if.sink           i_row,
    input  logic              i_full,
    output logic              o_push,
    output t_job              o_job
);

    logic [ROW_W-1:0] r_older;
    logic [ROW_W-1:0] r_pending;
    logic             r_have;
    logic             r_hold;
    t_job             r_job_b;

    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] row_m;
    logic [ROW_W-1:0] pend_m;
    logic [ROW_W-1:0] older_new;
    logic             accept;
    t_job             job_a;
    t_job             job_b;

    // Take a row only when no second job waits and the queue has room
    assign i_row.ready = !r_hold && !i_full;
    assign accept      = i_row.valid && i_row.ready;

    // Mask rows to the columns in use and build the jobs
    always_comb begin
        mask      = ~({ROW_W{1'b1}} << i_ncols);
        row_m     = i_row.row_bits & mask;
        pend_m    = r_pending & mask;
        older_new = r_have ? pend_m : '0;

        job_a.above  = r_older & mask;
        job_a.mid    = pend_m;
        job_a.below  = row_m;
        job_a.ncols  = i_ncols;
        job_a.newest = 1'b0;
        job_a.last   = !i_row.last_row;

        job_b.above  = older_new;
        job_b.mid    = row_m;
        job_b.below  = '0;
        job_b.ncols  = i_ncols;
        job_b.newest = 1'b1;
        job_b.last   = 1'b1;
    end

    // Push the held final-row job first, else the job of the row taken now
    always_comb begin
        if (r_hold) begin
            o_push = !i_full;
            o_job  = r_job_b;
        end else begin
            o_push = accept && (r_have || i_row.last_row);
            o_job  = r_have ? job_a : job_b;
        end
    end

    // Advance the row history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older   <= '0;
            r_pending <= '0;
            r_have    <= 1'b0;
            r_hold    <= 1'b0;
        end else if (accept) begin
            r_hold  <= r_have && i_row.last_row;
            r_job_b <= job_b;
            if (i_row.last_row) begin
                r_older   <= '0;
                r_pending <= '0;
                r_have    <= 1'b0;
            end else begin
                r_older   <= older_new;
                r_pending <= row_m;
                r_have    <= 1'b1;
            end
        end else if (r_hold && !i_full) begin
            r_hold <= 1'b0;
        end
    end

endmodule

/* hw/rtl/gnc_job_queue.sv */
// Two-entry queue of count jobs between the front end and the back end.
// Depends on gnc_pkg for the job type.
module gnc_job_queue
    import gnc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rd];

    // Store a job
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Move pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= !r_wr;
            end
            if (i_pop && o_valid) begin
                r_rd <= !r_rd;
            end
            unique case ({i_push && !o_full, i_pop && o_valid})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hw/rtl/gnc_back.sv */
// Back end: walks the columns of the head job, one count per cycle unless the
// output stalls, into an output register. Depends on gnc_pkg and gnc_count_if.
module gnc_back
    import gnc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    gnc_count_if.source o_count
);

    logic [COL_W-1:0] r_col;
    logic             r_valid;
    logic [CNT_W-1:0] r_count;
    logic [COL_W-1:0] r_column;
    logic             r_newest;
    logic             r_last;

    logic             advance;
    logic             last_col;
    logic [ROW_W:0]   sh_above;
    logic [ROW_W:0]   sh_mid;
    logic [ROW_W:0]   sh_below;
    logic [CNT_W-1:0] count;

    assign advance  = i_valid && (!r_valid || o_count.ready);
    assign last_col = {1'b0, r_col} == (i_job.ncols - NCOL_W'(1));
    assign o_pop    = advance && last_col;

    // Sum the three bits around the current column in each row
    always_comb begin
        sh_above = {i_job.above, 1'b0} >> r_col;
        sh_mid   = {i_job.mid,   1'b0} >> r_col;
        sh_below = {i_job.below, 1'b0} >> r_col;
        count = CNT_W'(sh_above[0]) + CNT_W'(sh_above[1]) + CNT_W'(sh_above[2])
              + CNT_W'(sh_mid[0])   + CNT_W'(sh_mid[1])   + CNT_W'(sh_mid[2])
              + CNT_W'(sh_below[0]) + CNT_W'(sh_below[1]) + CNT_W'(sh_below[2]);
    end

    // Step the column counter and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_col   <= last_col ? '0 : r_col + COL_W'(1);
                r_valid <= 1'b1;
            end else if (o_count.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_count  <= count;
            r_column <= r_col;
            r_newest <= i_job.newest;
            r_last   <= i_job.last && last_col;
        end
    end

    assign o_count.valid      = r_valid;
    assign o_count.cell_count = r_count;
    assign o_count.column     = r_column;
    assign o_count.newest_row = r_newest;
    assign o_count.last       = r_last;

endmodule

/* hw/rtl/grid_neighbor_count_3x3.sv */
// Mine counter over a binary grid that arrives one row per transfer. Each
// row's counts leave one column per cycle, set by the column walk in the
// back end, while the output is not stalled. A row's counts start once
// the row below it arrives; the final row also sends its own counts.
// A two-entry job queue lets rows be taken while earlier counts drain.
// grid_cols (address 0) sets the columns in use; 0 acts as 1, above 32 as 32.
// Depends on gnc_pkg, gnc_row_if, gnc_count_if, gnc_front, gnc_job_queue
// and gnc_back.
module grid_neighbor_count_3x3
    import gnc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    gnc_row_if.sink            i_row,
    gnc_count_if.source        o_count
);

    logic [CFG_W-1:0]  r_grid_cols;
    logic [NCOL_W-1:0] ncols;
    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    t_job              push_job;
    t_job              head_job;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRID_COLS) ? PDATA_W'(r_grid_cols) : '0;

    // Write the column count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_GRID_COLS) begin
            r_grid_cols <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the column count to the supported range
    always_comb begin
        priority if (r_grid_cols == '0) begin
            ncols = NCOL_W'(1);
        end else if (r_grid_cols > CFG_W'(MAX_COLS)) begin
            ncols = NCOL_W'(MAX_COLS);
        end else begin
            ncols = NCOL_W'(r_grid_cols);
        end
    end

    gnc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ncols (ncols),
        .i_row   (i_row),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    gnc_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    gnc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_count (o_count)
    );

endmodule
